// ----- hdl/ray_triangle_parity_inside_test_assert.svh -----
// Assertion macros for the ray/triangle parity inside test.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef RAY_TRIANGLE_PARITY_INSIDE_TEST_ASSERT_SVH
`define RAY_TRIANGLE_PARITY_INSIDE_TEST_ASSERT_SVH

// same-cycle implication
`define RTPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rtpi_pkg.sv -----
// Shared constants, types and the multiply-accumulate microcode of the
// ray/triangle parity inside test. No dependencies.
package rtpi_pkg;

	localparam int MAX_TRIANGLES_DEF = 4096;
	localparam int COORD_BITS_DEF    = 32;
	localparam int FIELD_W           = 32;
	localparam int CNT_W             = 13;
	localparam int IDX_W             = 12;
	localparam int CORNER_W          = 2;
	localparam int PADDR_W           = 4;
	localparam int PDATA_W           = 32;

	localparam logic [CORNER_W-1:0] CORNERS = 2'd3;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_COUNT = 2'd0,
		REG_OX    = 2'd1,
		REG_OY    = 2'd2,
		REG_OZ    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		VA_D  = 2'd0,
		VA_E1 = 2'd1,
		VA_E2 = 2'd2,
		VA_S  = 2'd3
	} asel_t;

	typedef enum logic [2:0] {
		VB_E1 = 3'd0,
		VB_E2 = 3'd1,
		VB_H  = 3'd2,
		VB_Q  = 3'd3
	} bsel_t;

	typedef enum logic [2:0] {
		DST_H = 3'd0,
		DST_Q = 3'd1,
		DST_A = 3'd2,
		DST_U = 3'd3,
		DST_V = 3'd4,
		DST_T = 3'd5
	} dst_t;

	typedef struct packed {
		asel_t       asel;
		logic [1:0]  aidx;
		bsel_t       bsel;
		logic [1:0]  bidx;
		logic        hi;
		logic        neg;
		logic        first;
		logic        last;
		dst_t        dst;
		logic [1:0]  dcomp;
	} mac_ctl_t;

	localparam logic [2:0] GRP_LAST = 3'd5;
	localparam logic [2:0] SUB_LAST = 3'd5;

	function automatic logic [1:0] mod3(input logic [2:0] v);
		logic [1:0] r;
		case (v)
			3'd0, 3'd3: r = 2'd0;
			3'd1, 3'd4: r = 2'd1;
			default:    r = 2'd2;
		endcase
		return r;
	endfunction

	// Groups: h = d x e2, q = s x e1, a = e1.h, u = s.h, v = d.q, t = e2.q.
	function automatic mac_ctl_t mac_op(input logic [2:0] grp, input logic [2:0] sub);
		mac_ctl_t   c;
		logic [1:0] comp;
		logic       odd;
		comp = sub[2:1];
		odd  = sub[0];
		c = '0;
		case (grp)
			3'd0: begin c.asel = VA_D;  c.bsel = VB_E2; c.dst = DST_H; end
			3'd1: begin c.asel = VA_S;  c.bsel = VB_E1; c.dst = DST_Q; end
			3'd2: begin c.asel = VA_E1; c.bsel = VB_H;  c.dst = DST_A; end
			3'd3: begin c.asel = VA_S;  c.bsel = VB_H;  c.dst = DST_U; end
			3'd4: begin c.asel = VA_D;  c.bsel = VB_Q;  c.dst = DST_V; end
			default: begin c.asel = VA_E2; c.bsel = VB_Q; c.dst = DST_T; end
		endcase
		if (grp < 3'd2) begin
			c.aidx  = mod3(3'(comp) + 3'd1 + 3'(odd));
			c.bidx  = mod3(3'(comp) + 3'd2 - 3'(odd));
			c.hi    = 1'b0;
			c.neg   = odd;
			c.first = !odd;
			c.last  = odd;
			c.dcomp = comp;
		end else begin
			c.aidx  = comp;
			c.bidx  = comp;
			c.hi    = odd;
			c.neg   = 1'b0;
			c.first = (sub == 3'd0);
			c.last  = (sub == SUB_LAST);
			c.dcomp = 2'd0;
		end
		return c;
	endfunction

endpackage

// ----- hdl/ray_triangle_parity_inside_test.sv -----
// Top level of the ray/triangle parity inside test: vertex store, sequencer,
// shared multiply-accumulate unit. Depends on rtpi_pkg, rtpi_ram and the assert header.
//
//   channel | direction | handshake              | words
//   in      | in        | in_valid / in_stall    | action, triangle_index, corner, coord_x/y/z
//   out     | out       | out_valid / out_stall  | inside_res
//   cfg     | in        | APB psel/penable/pready| triangle_count, outside_x/y/z
//
// A valid load is written into the vertex store when accepted. Per triangle, a query runs
// a vertex fetch, 36 products through the one shared multiplier, a drain and two evaluation
// states; after the last triangle it posts the result. Reset clears control only; vertices
// are undefined until loaded.
// in_stall is high while a query runs; a finished result waits in the output
// register under out_stall, and new words are taken meanwhile.
`include "ray_triangle_parity_inside_test_assert.svh"

module ray_triangle_parity_inside_test
	import rtpi_pkg::*;
#(
	parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [IDX_W-1:0]    triangle_index,
	input  logic [CORNER_W-1:0] corner,
	input  logic [FIELD_W-1:0]  coord_x,
	input  logic [FIELD_W-1:0]  coord_y,
	input  logic [FIELD_W-1:0]  coord_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                inside_res
);

	localparam int DW    = COORD_BITS + 1;
	localparam int BW    = DW + 1;
	localparam int HW    = 2 * DW + 1;
	localparam int PW    = DW + BW;
	localparam int ACCW  = 3 * DW + 4;
	localparam int SLOTS = 3 * MAX_TRIANGLES;
	localparam int AW    = $clog2(SLOTS);
	localparam int TW    = $clog2(MAX_TRIANGLES + 1);
	localparam int SW    = (AW > IDX_W + 3) ? AW : IDX_W + 3;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_MAC   = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_EVAL1 = 7'b0010000,
		S_EVAL2 = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	function automatic logic signed [DW-1:0] sx_in(input logic [FIELD_W-1:0] v);
		return {v[COORD_BITS-1], v[COORD_BITS-1:0]};
	endfunction

	function automatic logic signed [DW-1:0] sx_st(input logic [COORD_BITS-1:0] v);
		return {v[COORD_BITS-1], v};
	endfunction

	function automatic logic signed [DW-1:0] pick3(input logic signed [DW-1:0] x0,
		input logic signed [DW-1:0] x1, input logic signed [DW-1:0] x2,
		input logic [1:0] idx);
		logic signed [DW-1:0] r;
		case (idx)
			2'd0:    r = x0;
			2'd1:    r = x1;
			default: r = x2;
		endcase
		return r;
	endfunction

	function automatic logic signed [HW-1:0] pick3w(input logic signed [HW-1:0] x0,
		input logic signed [HW-1:0] x1, input logic signed [HW-1:0] x2,
		input logic [1:0] idx);
		logic signed [HW-1:0] r;
		case (idx)
			2'd0:    r = x0;
			2'd1:    r = x1;
			default: r = x2;
		endcase
		return r;
	endfunction

	// configuration
	logic [CNT_W-1:0]   count_q;
	logic [FIELD_W-1:0] ox_q, oy_q, oz_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			oz_q    <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				REG_OX:    ox_q    <= pwdata;
				REG_OY:    oy_q    <= pwdata;
				REG_OZ:    oz_q    <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_COUNT: prdata = PDATA_W'(count_q);
			REG_OX:    prdata = ox_q;
			REG_OY:    prdata = oy_q;
			REG_OZ:    prdata = oz_q;
		endcase
	end

	// handshake
	state_t state_q;
	logic   in_acc;
	logic   out_valid_q, inside_q;

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

	// vertex store
	logic [SW-1:0]         slot_w;
	logic                  load_ok, ram_we, ram_re;
	logic [AW-1:0]         raddr;
	logic [COORD_BITS-1:0] rd_x, rd_y, rd_z;
	logic [AW-1:0]         base_q;
	logic [1:0]            fc_q;

	assign slot_w  = SW'({triangle_index, 1'b0}) + SW'(triangle_index) + SW'(corner);
	assign load_ok = (32'(triangle_index) < 32'(MAX_TRIANGLES)) && (corner < CORNERS);
	assign ram_we  = in_acc && (action == ACT_LOAD) && load_ok;
	assign ram_re  = (state_q == S_FETCH) && (fc_q != 2'd3);
	assign raddr   = base_q + AW'(fc_q);

	rtpi_ram #(.WIDTH(COORD_BITS), .DEPTH(SLOTS)) u_ram_x (
		.clk, .we(ram_we), .waddr(slot_w[AW-1:0]), .wdata(coord_x[COORD_BITS-1:0]),
		.re(ram_re), .raddr, .rdata(rd_x));
	rtpi_ram #(.WIDTH(COORD_BITS), .DEPTH(SLOTS)) u_ram_y (
		.clk, .we(ram_we), .waddr(slot_w[AW-1:0]), .wdata(coord_y[COORD_BITS-1:0]),
		.re(ram_re), .raddr, .rdata(rd_y));
	rtpi_ram #(.WIDTH(COORD_BITS), .DEPTH(SLOTS)) u_ram_z (
		.clk, .we(ram_we), .waddr(slot_w[AW-1:0]), .wdata(coord_z[COORD_BITS-1:0]),
		.re(ram_re), .raddr, .rdata(rd_z));

	// per-query and per-triangle vectors
	logic signed [DW-1:0] px_q, py_q, pz_q;
	logic signed [DW-1:0] d0_q, d1_q, d2_q;
	logic signed [DW-1:0] s0_q, s1_q, s2_q;
	logic signed [DW-1:0] e10_q, e11_q, e12_q;
	logic signed [DW-1:0] e20_q, e21_q, e22_q;
	logic [COORD_BITS-1:0] v0x_q, v0y_q, v0z_q;
	logic signed [HW-1:0] h0_q, h1_q, h2_q, q0_q, q1_q, q2_q;
	logic [ACCW-1:0]      a_q, u_q, v_q, t_q, acc_q;

	// sequencer counters
	logic [TW-1:0] tri_q, lim_q;
	logic [2:0]    grp_q, sub_q;
	logic          parity_q;
	logic [TW-1:0] lim_w;

	assign lim_w = (32'(count_q) > 32'(MAX_TRIANGLES)) ? TW'(MAX_TRIANGLES) : TW'(count_q);

	// shared multiplier operand select
	mac_ctl_t             ctl;
	logic signed [DW-1:0] opa, nb;
	logic signed [HW-1:0] wb;
	logic signed [BW-1:0] opb;

	assign ctl = mac_op(grp_q, sub_q);

	always_comb begin
		unique case (ctl.asel)
			VA_D:  opa = pick3(d0_q, d1_q, d2_q, ctl.aidx);
			VA_E1: opa = pick3(e10_q, e11_q, e12_q, ctl.aidx);
			VA_E2: opa = pick3(e20_q, e21_q, e22_q, ctl.aidx);
			VA_S:  opa = pick3(s0_q, s1_q, s2_q, ctl.aidx);
		endcase
		nb = (ctl.bsel == VB_E1) ? pick3(e10_q, e11_q, e12_q, ctl.bidx)
		                         : pick3(e20_q, e21_q, e22_q, ctl.bidx);
		wb = (ctl.bsel == VB_H) ? pick3w(h0_q, h1_q, h2_q, ctl.bidx)
		                        : pick3w(q0_q, q1_q, q2_q, ctl.bidx);
		if (ctl.bsel == VB_H || ctl.bsel == VB_Q) begin
			opb = ctl.hi ? wb[HW-1:DW] : {1'b0, wb[DW-1:0]};
		end else begin
			opb = {nb[DW-1], nb};
		end
	end

	// multiplier stage
	logic signed [PW-1:0] prod_s1;
	logic                 valid_s1, hi_s1, neg_s1, first_s1, last_s1;
	dst_t                 dst_s1;
	logic [1:0]           dcomp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_MAC);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= opa * opb;
		hi_s1    <= ctl.hi;
		neg_s1   <= ctl.neg;
		first_s1 <= ctl.first;
		last_s1  <= ctl.last;
		dst_s1   <= ctl.dst;
		dcomp_s1 <= ctl.dcomp;
	end

	// accumulate stage
	logic signed [ACCW-1:0] ext, shifted;
	logic [ACCW-1:0]        acc_nxt;

	always_comb begin
		ext     = ACCW'(prod_s1);
		shifted = hi_s1 ? (ext <<< DW) : ext;
		acc_nxt = (first_s1 ? '0 : acc_q) + (neg_s1 ? ~shifted : shifted) + ACCW'(neg_s1);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= acc_nxt;
			if (last_s1) begin
				case (dst_s1)
					DST_H: begin
						case (dcomp_s1)
							2'd0:    h0_q <= acc_nxt[HW-1:0];
							2'd1:    h1_q <= acc_nxt[HW-1:0];
							default: h2_q <= acc_nxt[HW-1:0];
						endcase
					end
					DST_Q: begin
						case (dcomp_s1)
							2'd0:    q0_q <= acc_nxt[HW-1:0];
							2'd1:    q1_q <= acc_nxt[HW-1:0];
							default: q2_q <= acc_nxt[HW-1:0];
						endcase
					end
					DST_A:   a_q <= acc_nxt;
					DST_U:   u_q <= acc_nxt;
					DST_V:   v_q <= acc_nxt;
					default: t_q <= acc_nxt;
				endcase
			end
		end
	end

	// evaluation
	logic signed [ACCW-1:0] an_s1, un_s1, vn_s1, tn_s1, uv;
	logic                   az_s1, hit;

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL1) begin
			az_s1 <= (a_q == '0);
			an_s1 <= a_q[ACCW-1] ? -a_q : a_q;
			un_s1 <= a_q[ACCW-1] ? -u_q : u_q;
			vn_s1 <= a_q[ACCW-1] ? -v_q : v_q;
			tn_s1 <= a_q[ACCW-1] ? -t_q : t_q;
		end
	end

	assign uv  = un_s1 + vn_s1;
	assign hit = !az_s1 && !un_s1[ACCW-1] && !(an_s1 < un_s1) && !vn_s1[ACCW-1]
	          && !(an_s1 < uv) && (tn_s1 > 0);

	// vector registers
	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_QUERY) begin
			px_q <= sx_in(coord_x);
			py_q <= sx_in(coord_y);
			pz_q <= sx_in(coord_z);
			d0_q <= sx_in(coord_x) - sx_in(ox_q);
			d1_q <= sx_in(coord_y) - sx_in(oy_q);
			d2_q <= sx_in(coord_z) - sx_in(oz_q);
		end
		if (state_q == S_FETCH) begin
			case (fc_q)
				2'd1: begin
					v0x_q <= rd_x;
					v0y_q <= rd_y;
					v0z_q <= rd_z;
					s0_q  <= px_q - sx_st(rd_x);
					s1_q  <= py_q - sx_st(rd_y);
					s2_q  <= pz_q - sx_st(rd_z);
				end
				2'd2: begin
					e10_q <= sx_st(rd_x) - sx_st(v0x_q);
					e11_q <= sx_st(rd_y) - sx_st(v0y_q);
					e12_q <= sx_st(rd_z) - sx_st(v0z_q);
				end
				2'd3: begin
					e20_q <= sx_st(rd_x) - sx_st(v0x_q);
					e21_q <= sx_st(rd_y) - sx_st(v0y_q);
					e22_q <= sx_st(rd_z) - sx_st(v0z_q);
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tri_q       <= '0;
			lim_q       <= '0;
			base_q      <= '0;
			fc_q        <= '0;
			grp_q       <= '0;
			sub_q       <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && action == ACT_QUERY) begin
						tri_q    <= '0;
						lim_q    <= lim_w;
						base_q   <= '0;
						fc_q     <= '0;
						parity_q <= 1'b0;
						state_q  <= (lim_w == '0) ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: begin
					fc_q <= fc_q + 2'd1;
					if (fc_q == 2'd3) begin
						grp_q   <= '0;
						sub_q   <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (sub_q == SUB_LAST) begin
						sub_q <= '0;
						grp_q <= grp_q + 3'd1;
						if (grp_q == GRP_LAST) begin
							state_q <= S_DRAIN;
						end
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				S_DRAIN: state_q <= S_EVAL1;
				S_EVAL1: state_q <= S_EVAL2;
				S_EVAL2: begin
					parity_q <= parity_q ^ hit;
					tri_q    <= tri_q + TW'(1);
					base_q   <= base_q + AW'(3);
					fc_q     <= '0;
					state_q  <= (tri_q + TW'(1) == lim_q) ? S_DONE : S_FETCH;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						inside_q <= parity_q;
						state_q  <= S_IDLE;
					end
				end
			endcase
		end
	end

	`RTPI_ASSERT_IMP(a_mac_only_busy, valid_s1, (state_q == S_MAC || state_q == S_DRAIN), "product in flight outside multiply phase")
	`RTPI_ASSERT_IMP(a_drained_eval, (state_q == S_EVAL1), !valid_s1, "evaluation began with product pending")
	`RTPI_ASSERT_IMP(a_tri_in_range, (state_q == S_FETCH || state_q == S_MAC || state_q == S_EVAL2), (tri_q < lim_q), "triangle index past limit")
	`RTPI_ASSERT_NEXT(a_query_start, (in_acc && action == ACT_QUERY), (state_q == S_FETCH || state_q == S_DONE), "query did not start")

endmodule

// ----- hdl/rtpi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- test/ray_triangle_parity_inside_test_tb.sv -----
// Self-checking bench for ray_triangle_parity_inside_test: loads meshes, queries points and
// compares each inside word with an exact 128-bit Moller-Trumbore parity predictor or, for
// some directed queries, a literal value. Depends on rtpi_pkg and the block itself.
module ray_triangle_parity_inside_test_tb;
	import rtpi_pkg::*;

	localparam int NTRI = 4096;
	localparam int WATCH_LIMIT = 400000;
	localparam logic [31:0] ONE = 32'h0001_0000;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		bit          cfg;
		reg_idx_t    r;
		logic [31:0] val;
		logic        act;
		logic [11:0] ti;
		logic [1:0]  cn;
		logic [31:0] x, y, z;
		bit          lit;
		bit          ev;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic action = 0;
	logic [IDX_W-1:0] triangle_index = '0;
	logic [CORNER_W-1:0] corner = '0;
	logic [FIELD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic out_valid, out_stall = 0, inside_res;

	logic [31:0] vx_mem[3*NTRI], vy_mem[3*NTRI], vz_mem[3*NTRI];
	logic [12:0] tri_cnt;
	logic [31:0] ox, oy, oz;
	bit inside_q[$];
	int s_pct = 0, r_pct = 0;
	int errors = 0, idle_cycles = 0;

	ray_triangle_parity_inside_test uut (.*);

	always #2 clk = ~clk;

	function automatic wide_t wx(logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	function automatic bit ray_crosses(int t, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		wide_t d[3], e1[3], e2[3], s[3], h[3], q[3];
		wide_t a, u, v, tt;
		int b;
		b = 3 * t;
		d[0] = wx(px) - wx(ox); d[1] = wx(py) - wx(oy); d[2] = wx(pz) - wx(oz);
		e1[0] = wx(vx_mem[b+1]) - wx(vx_mem[b]);
		e1[1] = wx(vy_mem[b+1]) - wx(vy_mem[b]);
		e1[2] = wx(vz_mem[b+1]) - wx(vz_mem[b]);
		e2[0] = wx(vx_mem[b+2]) - wx(vx_mem[b]);
		e2[1] = wx(vy_mem[b+2]) - wx(vy_mem[b]);
		e2[2] = wx(vz_mem[b+2]) - wx(vz_mem[b]);
		s[0] = wx(px) - wx(vx_mem[b]);
		s[1] = wx(py) - wx(vy_mem[b]);
		s[2] = wx(pz) - wx(vz_mem[b]);
		h[0] = d[1]*e2[2] - d[2]*e2[1];
		h[1] = d[2]*e2[0] - d[0]*e2[2];
		h[2] = d[0]*e2[1] - d[1]*e2[0];
		a = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
		if (a == 0)
			return 0;
		q[0] = s[1]*e1[2] - s[2]*e1[1];
		q[1] = s[2]*e1[0] - s[0]*e1[2];
		q[2] = s[0]*e1[1] - s[1]*e1[0];
		u = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
		v = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
		tt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
		if (a < 0) begin
			a = -a; u = -u; v = -v; tt = -tt;
		end
		return u >= 0 && u <= a && v >= 0 && u + v <= a && tt > 0;
	endfunction

	function automatic bit inside_parity(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		int n;
		bit p;
		n = tri_cnt > NTRI ? NTRI : tri_cnt;
		p = 0;
		for (int i = 0; i < n; i++)
			p ^= ray_crosses(i, px, py, pz);
		return p;
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return ($urandom_range(0, 16) << 16) - (32'd8 << 16) + ($urandom_range(0, 3) << 14);
	endfunction

	task automatic write_reg(reg_idx_t r, logic [31:0] val);
		in_valid = 0;
		while (inside_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = {r, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		case (r)
			REG_COUNT: tri_cnt = val[12:0];
			REG_OX:    ox = val;
			REG_OY:    oy = val;
			REG_OZ:    oz = val;
		endcase
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic send_word(logic act, logic [11:0] ti, logic [1:0] cn,
			logic [31:0] x, logic [31:0] y, logic [31:0] z, bit lit, bit ev);
		if ($urandom_range(0, 99) < s_pct) begin
			in_valid = 0;
			do @(negedge clk); while ($urandom_range(0, 99) < s_pct);
		end
		action = act; triangle_index = ti; corner = cn;
		coord_x = x; coord_y = y; coord_z = z;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		if (act == ACT_LOAD) begin
			if (cn < CORNERS) begin
				vx_mem[3*ti+cn] = x; vy_mem[3*ti+cn] = y; vz_mem[3*ti+cn] = z;
			end
		end else
			inside_q = {inside_q, lit ? ev : inside_parity(x, y, z)};
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_stall <= arst_n && ($urandom_range(0, 99) < r_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("ray_triangle_parity_inside_test_tb NOT OK");
				$finish;
			end else if (out_valid && !out_stall) begin
				if (inside_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word inside_res=%0d", inside_res);
				end else begin
					if (inside_res !== inside_q[0]) begin
						errors++;
						if (errors <= 10)
							$display("inside_res mismatch: want %0d got %0d",
								inside_q[0], inside_res);
					end
					void'(inside_q.pop_front());
				end
			end
		end
	end

	row_t dir_rows[] = '{
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'd0, 32'd0, 32'd0, 1, 0},
		'{0, REG_COUNT, 0, ACT_LOAD, 12'd0, 2'd0, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0, 0, 0},
		'{0, REG_COUNT, 0, ACT_LOAD, 12'd0, 2'd1, ONE, 32'hFFFF_0000, 32'd0, 0, 0},
		'{0, REG_COUNT, 0, ACT_LOAD, 12'd0, 2'd2, 32'd0, ONE, 32'd0, 0, 0},
		'{0, REG_COUNT, 0, ACT_LOAD, 12'd4095, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 0},
		'{0, REG_COUNT, 0, ACT_LOAD, 12'd4095, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 0, 0},
		'{1, REG_COUNT, 32'd1, ACT_LOAD, 12'd0, 2'd0, 32'd0, 32'd0, 32'd0, 0, 0},
		'{1, REG_OZ, 32'hFFF6_0000, ACT_LOAD, 12'd0, 2'd0, 32'd0, 32'd0, 32'd0, 0, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'd0, 32'd0, 32'h0005_0000, 0, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'hABC, 2'd3, 32'd0, 32'd0, 32'hFFFB_0000, 0, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'd0, 32'd0, 32'hFFF6_0000, 1, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'h0003_0000, 32'd0, 32'h0005_0000, 0, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 0},
		'{1, REG_COUNT, 32'd0, ACT_LOAD, 12'd0, 2'd0, 32'd0, 32'd0, 32'd0, 0, 0},
		'{0, REG_COUNT, 0, ACT_QUERY, 12'd0, 2'd0, 32'd0, 32'd0, 32'h0005_0000, 1, 0}
	};

	initial begin
		int sp[4] = '{0, 88, 0, 19};
		int rp[4] = '{0, 0, 88, 19};
		tri_cnt = '0; ox = '0; oy = '0; oz = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg)
				write_reg(dir_rows[i].r, dir_rows[i].val);
			else
				send_word(dir_rows[i].act, dir_rows[i].ti, dir_rows[i].cn, dir_rows[i].x,
					dir_rows[i].y, dir_rows[i].z, dir_rows[i].lit, dir_rows[i].ev);
		end
		// fill the triangles that the random phases query
		for (int t = 0; t < 12; t++)
			for (int c = 0; c < 3; c++)
				send_word(ACT_LOAD, t, c, rand_coord(), rand_coord(), rand_coord(), 0, 0);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_COUNT, $urandom_range(1, 12));
			write_reg(REG_OX, ph == 3 ? 32'h8000_0000 : rand_coord());
			write_reg(REG_OY, ph == 3 ? 32'h7FFF_FFFF : rand_coord());
			write_reg(REG_OZ, ph == 3 ? 32'h8000_0000 : rand_coord());
			s_pct = sp[ph]; r_pct = rp[ph];
			for (int k = 0; k < 15; k++) begin
				if ($urandom_range(0, 2) == 0)
					send_word(ACT_QUERY, $urandom, $urandom, rand_coord(), rand_coord(),
						rand_coord(), 0, 0);
				else
					send_word(ACT_LOAD, $urandom_range(0, 11),
						$urandom_range(0, 5) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
						rand_coord(), rand_coord(), rand_coord(), 0, 0);
			end
			in_valid = 0;
			s_pct = 0;
		end
		while (inside_q.size() != 0)
			@(negedge clk);
		r_pct = 0;
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("ray_triangle_parity_inside_test_tb OK");
		else
			$display("ray_triangle_parity_inside_test_tb NOT OK");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rtpi_pkg.sv
hdl/rtpi_ram.sv
hdl/ray_triangle_parity_inside_test.sv
test/ray_triangle_parity_inside_test_tb.sv
